@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the stereo master gain meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros use the clk and rst_n of the module in which they are expanded.
`define SMGM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smgm assertion failed in the same cycle");

`define SMGM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smgm assertion failed in the following cycle");

`endif

@@ hw/rtl/smgm_pkg.sv @@
// Package with the shared constants and types of the stereo master gain meter.
`timescale 1ns / 1ps
`default_nettype none

package smgm_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_BLOCK_DEF   = 4096;

  localparam int GAIN_W = 16;
  localparam int FRAC_W = 14;
  localparam int ACC_W  = 64;
  localparam int ROOT_W = 32;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  typedef enum logic {
    REG_GAIN = 1'b0,
    REG_MONO = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              mono;
  } smgm_cfg_t;

  typedef struct packed {
    logic load;
    logic sat;
    logic sqr;
    logic acc;
    logic root_start;
    logic root_right;
    logic take_rms;
    logic emit;
  } smgm_cmd_t;

  typedef struct packed {
    logic close;
    logic root_done;
    logic out_free;
  } smgm_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/smgm_if.sv @@
// Stream interfaces for the sample pair input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface smgm_in_if #(
  parameter int SAMPLE_BITS = smgm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          last_in_block;

  modport source (output valid, left_in, right_in, last_in_block, input ready);
  modport sink   (input valid, left_in, right_in, last_in_block, output ready);
endinterface

interface smgm_out_if #(
  parameter int SAMPLE_BITS = smgm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          meters_valid;
  logic        [SAMPLE_BITS-1:0] peak_left;
  logic        [SAMPLE_BITS-1:0] peak_right;
  logic        [SAMPLE_BITS-1:0] rms_left;
  logic        [SAMPLE_BITS-1:0] rms_right;

  modport source (output valid, out_left, out_right, meters_valid, peak_left, peak_right,
                  rms_left, rms_right, input ready);
  modport sink   (input valid, out_left, out_right, meters_valid, peak_left, peak_right,
                  rms_left, rms_right, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/smgm_regs.sv @@
// APB-style configuration registers holding the master gain and the mono mode.
`timescale 1ns / 1ps
`default_nettype none

module smgm_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smgm_pkg::ADDR_W-1:0]   paddr,
  input  logic [smgm_pkg::DATA_W-1:0]   pwdata,
  output logic [smgm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output smgm_pkg::smgm_cfg_t           cfg
);
  import smgm_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic              mono_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      mono_r <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN: gain_r <= pwdata[GAIN_W-1:0];
        REG_MONO: mono_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN: prdata = DATA_W'(gain_r);
      REG_MONO: prdata = DATA_W'(mono_r);
      default:  prdata = '0;
    endcase
  end

  assign cfg.gain = gain_r;
  assign cfg.mono = mono_r;

endmodule

`default_nettype wire

@@ hw/rtl/smgm_divsqrt.sv @@
// Iterative unit that divides a square sum by the sample count and takes the integer root.
`timescale 1ns / 1ps
`default_nettype none

module smgm_divsqrt #(
  parameter int CNT_W = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [smgm_pkg::ACC_W-1:0]  dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        busy,
  output logic                        done,
  output logic [smgm_pkg::ROOT_W-1:0] root
);
  import smgm_pkg::*;

  localparam int STEP_W = $clog2(ACC_W);
  localparam int SREM_W = ROOT_W + 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_SQRT
  } phase_t;

  phase_t              phase_r;
  logic [STEP_W-1:0]   step_r;
  logic [ACC_W-1:0]    num_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    div_r;
  logic [SREM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]   root_r;
  logic                done_r;

  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      rem_dif;
  logic                div_ge;
  logic [SREM_W-1:0]   srem_sh;
  logic [SREM_W-1:0]   trial;
  logic [SREM_W-1:0]   srem_dif;
  logic                sq_ge;

  assign rem_sh   = {rem_r, num_r[ACC_W-1]};
  assign rem_dif  = rem_sh - {1'b0, div_r};
  assign div_ge   = rem_sh >= {1'b0, div_r};
  assign srem_sh  = {srem_r[ROOT_W-1:0], num_r[ACC_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign srem_dif = srem_sh - trial;
  assign sq_ge    = srem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        PH_IDLE: begin
          if (start) begin
            num_r   <= dividend;
            div_r   <= divisor;
            rem_r   <= '0;
            step_r  <= STEP_W'(ACC_W - 1);
            phase_r <= PH_DIV;
          end
        end
        PH_DIV: begin
          rem_r <= div_ge ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          num_r <= {num_r[ACC_W-2:0], div_ge};
          if (step_r == '0) begin
            step_r  <= STEP_W'(ROOT_W - 1);
            srem_r  <= '0;
            root_r  <= '0;
            phase_r <= PH_SQRT;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        PH_SQRT: begin
          srem_r <= sq_ge ? srem_dif : srem_sh;
          root_r <= {root_r[ROOT_W-2:0], sq_ge};
          num_r  <= {num_r[ACC_W-3:0], 2'b00};
          if (step_r == '0) begin
            done_r  <= 1'b1;
            phase_r <= PH_IDLE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign busy = (phase_r != PH_IDLE);
  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

@@ hw/rtl/smgm_dp.sv @@
// Datapath with gain, saturation, mono mix, block meters and the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module smgm_dp #(
  parameter int SAMPLE_BITS = smgm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BLOCK   = smgm_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smgm_pkg::smgm_cfg_t           cfg,
  input  smgm_pkg::smgm_cmd_t           cmd,
  output smgm_pkg::smgm_sts_t           sts,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          out_meters_valid,
  output logic        [SAMPLE_BITS-1:0] out_peak_left,
  output logic        [SAMPLE_BITS-1:0] out_peak_right,
  output logic        [SAMPLE_BITS-1:0] out_rms_left,
  output logic        [SAMPLE_BITS-1:0] out_rms_right
);
  import smgm_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int PROD_W = SB + GAIN_W + 1;
  localparam int Q_W    = PROD_W - FRAC_W;
  localparam int SQ_W   = 2 * SB;
  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);

  localparam logic signed [SB-1:0] S_MAX   = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN   = {1'b1, {(SB-1){1'b0}}};
  localparam logic [ROOT_W-1:0]    RMS_CAP = ROOT_W'(1) << (SB - 1);
  localparam logic [CNT_W-1:0]     CNT_MAX = CNT_W'(MAX_BLOCK);

  function automatic logic signed [SB-1:0] sat_gain(input logic signed [Q_W-1:0] q);
    logic [Q_W-SB:0]   top;
    logic signed [SB-1:0] res;
    top = q[Q_W-1:SB-1];
    if (top == '0 || top == '1) begin
      res = q[SB-1:0];
    end else if (q[Q_W-1]) begin
      res = S_MIN;
    end else begin
      res = S_MAX;
    end
    return res;
  endfunction

  function automatic logic [SB-1:0] mag_of(input logic signed [SB-1:0] g);
    logic [SB-1:0] u;
    u = g;
    return g[SB-1] ? SB'(~u + 1'b1) : u;
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  logic signed [PROD_W-1:0] prod_l_r, prod_r_r;
  logic                     last_r;
  logic signed [SB-1:0]     gain_l_r, gain_r_r;
  logic [SB-1:0]            mag_l_r, mag_r_r;
  logic [SQ_W-1:0]          sq_l_r, sq_r_r;
  logic [SB-1:0]            peak_l_r, peak_r_r;
  logic [ACC_W-1:0]         sum_l_r, sum_r_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     close_r;
  logic [SB-1:0]            rms_l_r, rms_r_r;

  logic                     out_valid_r;
  logic signed [SB-1:0]     out_left_r, out_right_r;
  logic                     out_mv_r;
  logic [SB-1:0]            out_peak_l_r, out_peak_r_r;
  logic [SB-1:0]            out_rms_l_r, out_rms_r_r;

  logic signed [Q_W-1:0]    q_l, q_r;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     close_now;
  logic [SB:0]              mix_sum;
  logic [ACC_W-1:0]         root_arg;
  logic                     root_busy;
  logic                     root_done;
  logic [ROOT_W-1:0]        root;
  logic [ROOT_W-1:0]        rms_clamp;
  logic                     out_free;
  logic                     clear_blk;
  logic                     blk_empty;
  logic                     out_meters_zero;

  assign q_l       = Q_W'(prod_l_r >>> FRAC_W);
  assign q_r       = Q_W'(prod_r_r >>> FRAC_W);
  assign cnt_inc   = cnt_r + 1'b1;
  assign close_now = last_r || (cnt_inc >= CNT_MAX);
  assign mix_sum   = {gain_l_r[SB-1], gain_l_r} + {gain_r_r[SB-1], gain_r_r};
  assign root_arg  = cmd.root_right ? sum_r_r : sum_l_r;
  assign rms_clamp = (root > RMS_CAP) ? RMS_CAP : root;
  assign out_free  = !out_valid_r || out_ready;
  assign clear_blk = cmd.emit && close_r;

  smgm_divsqrt #(
    .CNT_W (CNT_W)
  ) u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .dividend (root_arg),
    .divisor  (cnt_r),
    .busy     (root_busy),
    .done     (root_done),
    .root     (root)
  );

  // Block state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_l_r    <= '0;
      peak_r_r    <= '0;
      sum_l_r     <= '0;
      sum_r_r     <= '0;
      cnt_r       <= '0;
      close_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sqr) begin
        if (mag_l_r > peak_l_r) peak_l_r <= mag_l_r;
        if (mag_r_r > peak_r_r) peak_r_r <= mag_r_r;
      end
      if (cmd.acc) begin
        sum_l_r <= sat_add(sum_l_r, ACC_W'(sq_l_r));
        sum_r_r <= sat_add(sum_r_r, ACC_W'(sq_r_r));
        cnt_r   <= cnt_inc;
        close_r <= close_now;
      end else if (cmd.emit) begin
        close_r <= 1'b0;
      end
      if (clear_blk) begin
        peak_l_r <= '0;
        peak_r_r <= '0;
        sum_l_r  <= '0;
        sum_r_r  <= '0;
        cnt_r    <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample pipeline and output payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_l_r <= PROD_W'(in_left) * PROD_W'($signed({1'b0, cfg.gain}));
      prod_r_r <= PROD_W'(in_right) * PROD_W'($signed({1'b0, cfg.gain}));
      last_r   <= in_last;
    end
    if (cmd.sat) begin
      gain_l_r <= sat_gain(q_l);
      gain_r_r <= sat_gain(q_r);
      mag_l_r  <= mag_of(sat_gain(q_l));
      mag_r_r  <= mag_of(sat_gain(q_r));
    end
    if (cmd.sqr) begin
      sq_l_r <= SQ_W'(mag_l_r) * SQ_W'(mag_l_r);
      sq_r_r <= SQ_W'(mag_r_r) * SQ_W'(mag_r_r);
    end
    if (cmd.take_rms) begin
      if (cmd.root_right) begin
        rms_r_r <= rms_clamp[SB-1:0];
      end else begin
        rms_l_r <= rms_clamp[SB-1:0];
      end
    end
    if (cmd.emit) begin
      out_left_r   <= cfg.mono ? mix_sum[SB:1] : gain_l_r;
      out_right_r  <= cfg.mono ? '0 : gain_r_r;
      out_mv_r     <= close_r;
      out_peak_l_r <= close_r ? peak_l_r : '0;
      out_peak_r_r <= close_r ? peak_r_r : '0;
      out_rms_l_r  <= close_r ? rms_l_r : '0;
      out_rms_r_r  <= close_r ? rms_r_r : '0;
    end
  end

  assign sts.close     = close_now;
  assign sts.root_done = root_done;
  assign sts.out_free  = out_free;

  assign out_valid        = out_valid_r;
  assign out_left         = out_left_r;
  assign out_right        = out_right_r;
  assign out_meters_valid = out_mv_r;
  assign out_peak_left    = out_peak_l_r;
  assign out_peak_right   = out_peak_r_r;
  assign out_rms_left     = out_rms_l_r;
  assign out_rms_right    = out_rms_r_r;

  assign blk_empty = (cnt_r == '0) && (sum_l_r == '0) && (sum_r_r == '0) &&
                     (peak_l_r == '0) && (peak_r_r == '0);
  assign out_meters_zero = (out_peak_l_r == '0) && (out_peak_r_r == '0) &&
                           (out_rms_l_r == '0) && (out_rms_r_r == '0);

  `SMGM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX)
  `SMGM_ASSERT_NXT(a_block_cleared, clear_blk, blk_empty)
  `SMGM_ASSERT_IMP(a_root_start_idle, cmd.root_start, !root_busy)
  `SMGM_ASSERT_IMP(a_meters_zero, out_valid_r && !out_mv_r, out_meters_zero)

endmodule

`default_nettype wire

@@ hw/rtl/smgm_ctrl.sv @@
// Controller state machine that sequences the datapath for each sample pair.
`timescale 1ns / 1ps
`default_nettype none

module smgm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smgm_pkg::smgm_sts_t sts,
  output smgm_pkg::smgm_cmd_t cmd
);
  import smgm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SAT,
    S_SQR,
    S_ACC,
    S_ROOT_L,
    S_WAIT_L,
    S_ROOT_R,
    S_WAIT_R,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.close) begin
          state_nxt = S_ROOT_L;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_ROOT_L: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_WAIT_L;
      end
      S_WAIT_L: begin
        if (sts.root_done) begin
          cmd.take_rms = 1'b1;
          state_nxt    = S_ROOT_R;
        end
      end
      S_ROOT_R: begin
        cmd.root_start = 1'b1;
        cmd.root_right = 1'b1;
        state_nxt      = S_WAIT_R;
      end
      S_WAIT_R: begin
        cmd.root_right = 1'b1;
        if (sts.root_done) begin
          cmd.take_rms = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

@@ hw/rtl/stereo_master_gain_meter_core.sv @@
// Top level of the stereo master gain meter: registers, controller and datapath.
// An ordinary pair passes the saturate, square and accumulate states and its result goes
// to the output register once that is free; the input is then ready again.
// A pair that closes a block also runs the shared divide and root unit for each channel,
// left then right (64 divide steps and 32 root steps each) before the result is emitted.
// Reset (rst_n, synchronous, active low) clears the meters, sets the gain to unity
// and stereo mode, and the registered input ready is set after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module stereo_master_gain_meter_core #(
  parameter int SAMPLE_BITS = smgm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BLOCK   = smgm_pkg::MAX_BLOCK_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  smgm_in_if.sink                     in_chan,
  smgm_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smgm_pkg::ADDR_W-1:0] paddr,
  input  logic [smgm_pkg::DATA_W-1:0] pwdata,
  output logic [smgm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import smgm_pkg::*;

  smgm_cfg_t cfg;
  smgm_cmd_t cmd;
  smgm_sts_t sts;
  logic      in_ready;

  smgm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smgm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_left          (in_chan.left_in),
    .in_right         (in_chan.right_in),
    .in_last          (in_chan.last_in_block),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_left         (out_chan.out_left),
    .out_right        (out_chan.out_right),
    .out_meters_valid (out_chan.meters_valid),
    .out_peak_left    (out_chan.peak_left),
    .out_peak_right   (out_chan.peak_right),
    .out_rms_left     (out_chan.rms_left),
    .out_rms_right    (out_chan.rms_right)
  );

  assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the stereo master gain meter core.
`timescale 1ns / 1ps

module tb;
  import smgm_pkg::*;

  localparam int SW         = SAMPLE_BITS_DEF;
  localparam int BLOCK_CAP  = MAX_BLOCK_DEF;
  localparam int CYCLE_CAP  = 1000000;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] mix_l;
    logic signed [SW-1:0] mix_r;
    logic                 meters;
    logic [SW-1:0]        peak_l;
    logic [SW-1:0]        peak_r;
    logic [SW-1:0]        rms_l;
    logic [SW-1:0]        rms_r;
  } meter_frame_t;

  class gain_meter_tracker;
    logic [GAIN_W-1:0]  gain;
    logic               mono;
    logic [SW-1:0]      peak_l;
    logic [SW-1:0]      peak_r;
    longint unsigned    energy_l;
    longint unsigned    energy_r;
    int unsigned        count;
    meter_frame_t       frames_due[$];
    int unsigned        faults;

    function new();
      gain     = GAIN_RESET;
      mono     = 1'b0;
      peak_l   = '0;
      peak_r   = '0;
      energy_l = 0;
      energy_r = 0;
      count    = 0;
      faults   = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_GAIN: gain = value[GAIN_W-1:0];
        REG_MONO: mono = value[0];
        default: ;
      endcase
    endfunction

    function logic signed [SW-1:0] scale(logic signed [SW-1:0] s);
      longint s64;
      longint g64;
      longint p;
      s64 = s;
      g64 = gain;
      p = (s64 * g64) >>> FRAC_W;
      if (p > longint'(S_MAX)) p = S_MAX;
      if (p < longint'(S_MIN)) p = S_MIN;
      return p[SW-1:0];
    endfunction

    function logic [SW-1:0] root_mean(longint unsigned total, int unsigned n);
      longint unsigned v;
      longint unsigned res;
      longint unsigned probe;
      v = total / n;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v = v - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res = res >> 1;
        end
        probe >>= 2;
      end
      if (res > (64'd1 << (SW-1))) res = 64'd1 << (SW-1);
      return res[SW-1:0];
    endfunction

    function void take_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic last);
      logic signed [SW-1:0] gl;
      logic signed [SW-1:0] gr;
      longint               al;
      longint               ar;
      longint               total;
      meter_frame_t         f;
      gl = scale(l);
      gr = scale(r);
      al = gl;
      ar = gr;
      if (al < 0) al = -al;
      if (ar < 0) ar = -ar;
      f = '0;
      if (mono) begin
        total = al;
        total = longint'(gl) + longint'(gr);
        total = total >>> 1;
        f.mix_l = total[SW-1:0];
        f.mix_r = '0;
      end else begin
        f.mix_l = gl;
        f.mix_r = gr;
      end
      if (al[SW-1:0] > peak_l) peak_l = al[SW-1:0];
      if (ar[SW-1:0] > peak_r) peak_r = ar[SW-1:0];
      energy_l = energy_l + longint'(al * al);
      energy_r = energy_r + longint'(ar * ar);
      count++;
      // A block that reaches the size limit closes on its own.
      if (count >= BLOCK_CAP) last = 1'b1;
      if (last) begin
        f.meters = 1'b1;
        f.peak_l = peak_l;
        f.peak_r = peak_r;
        f.rms_l  = root_mean(energy_l, count);
        f.rms_r  = root_mean(energy_r, count);
        peak_l   = '0;
        peak_r   = '0;
        energy_l = 0;
        energy_r = 0;
        count    = 0;
      end
      frames_due = {frames_due, f};
    endfunction

    function void check_frame(meter_frame_t got);
      meter_frame_t want;
      logic         bad;
      if (frames_due.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result transfer: L=%0d R=%0d meters=%0b",
                                   got.mix_l, got.mix_r, got.meters);
        return;
      end
      want = frames_due.pop_front();
      bad = (got.mix_l !== want.mix_l) || (got.mix_r !== want.mix_r) ||
            (got.meters !== want.meters) || (got.peak_l !== want.peak_l) ||
            (got.peak_r !== want.peak_r) || (got.rms_l !== want.rms_l) ||
            (got.rms_r !== want.rms_r);
      if (bad) begin
        faults++;
        if (faults <= 10) begin
          $display("mismatch expected L=%0d R=%0d M=%0b PL=%0d PR=%0d RL=%0d RR=%0d",
                   want.mix_l, want.mix_r, want.meters, want.peak_l, want.peak_r,
                   want.rms_l, want.rms_r);
          $display("         actual   L=%0d R=%0d M=%0b PL=%0d PR=%0d RL=%0d RR=%0d",
                   got.mix_l, got.mix_r, got.meters, got.peak_l, got.peak_r,
                   got.rms_l, got.rms_r);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                bursts_on = 1'b1;
  int                  rx_hold = 0;
  int unsigned         cycles = 0;
  meter_frame_t        rx_frame;
  gain_meter_tracker   tracker = new();

  smgm_in_if  in_bus ();
  smgm_out_if out_bus ();

  stereo_master_gain_meter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      rx_frame.mix_l  = out_bus.out_left;
      rx_frame.mix_r  = out_bus.out_right;
      rx_frame.meters = out_bus.meters_valid;
      rx_frame.peak_l = out_bus.peak_left;
      rx_frame.peak_r = out_bus.peak_right;
      rx_frame.rms_l  = out_bus.rms_left;
      rx_frame.rms_r  = out_bus.rms_right;
      tracker.check_frame(rx_frame);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_bus.ready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(0, 6);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  function automatic logic signed [SW-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: begin
        v = $urandom_range(0, 64);
        return SW'(v - 32);
      end
      3: return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return GAIN_RESET;
      default: return GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r, logic last);
    int gap;
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.left_in       <= l;
    in_bus.right_in      <= r;
    in_bus.last_in_block <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.take_pair(l, r, last);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, value);
  endtask

  task automatic set_mode(logic [GAIN_W-1:0] gain, logic mono);
    write_reg(REG_GAIN, {16'($urandom), gain});
    write_reg(REG_MONO, {31'($urandom), mono});
  endtask

  task automatic run_blocks(int n);
    int span;
    int k;
    while (n > 0) begin
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      for (k = 0; k < span && n > 0; k++) begin
        send_pair(pick_sample(), pick_sample(),
                  (k == span - 1) || ($urandom_range(0, 19) == 0));
        n--;
      end
    end
  endtask

  initial begin
    int p;
    in_bus.valid         <= 1'b0;
    in_bus.left_in       <= '0;
    in_bus.right_in      <= '0;
    in_bus.last_in_block <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unity gain, stereo.
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair('0, '0, 1'b0);
    send_pair(-1, 1, 1'b0);
    send_pair(S_MAX, S_MAX, 1'b1);
    send_pair(S_MIN, S_MIN, 1'b1);
    settle();

    // Largest gain in mono mode: saturation and the floor of a negative half sum.
    set_mode('1, 1'b1);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(S_MIN, S_MIN, 1'b0);
    send_pair(1, -1, 1'b0);
    send_pair(-1, -1, 1'b0);
    send_pair(-3, '0, 1'b1);
    settle();

    set_mode('0, 1'b0);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(5, -5, 1'b1);
    settle();

    for (p = 0; p < 7; p++) begin
      set_mode(p == 0 ? GAIN_RESET : pick_gain(), p[0]);
      run_blocks(70);
      settle();
    end

    bursts_on = 1'b0;
    set_mode(pick_gain(), 1'($urandom));
    run_blocks(80);
    settle();
    repeat (250) @(posedge clk);

    if (tracker.faults == 0 && tracker.frames_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
